/* rtl/udw_pkg.sv */
// ----------------------------------------------------------------------------
// udw_pkg
// Types, constants and byte classification helpers for the UTF-8 display
// width block.
// ----------------------------------------------------------------------------
package udw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } udw_in_t;

  typedef struct packed {
    logic [14:0] text_width;
    logic        saturated;
  } udw_out_t;

  typedef struct packed {
    logic [4:0] narrow_width;
    logic [4:0] wide_width;
    logic [4:0] tsheg_width;
  } udw_cfg_t;

  // Open sequence: bytes held (first byte lowest), count, lead class
  typedef struct packed {
    logic [23:0] held_bytes;
    logic [1:0]  held_count;
    logic [1:0]  lead_class;
  } udw_hold_t;

  typedef struct packed {
    udw_hold_t  hold;
    logic [6:0] add;
  } udw_step_t;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_NARROW = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIDE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TSHEG  = 2'd2;

  localparam logic [1:0] LEAD_NONE  = 2'd0;
  localparam logic [1:0] LEAD_TWO   = 2'd1;
  localparam logic [1:0] LEAD_THREE = 2'd2;
  localparam logic [1:0] LEAD_FOUR  = 2'd3;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

  localparam logic [15:0] CP_TIB_LO    = 16'h0F00;
  localparam logic [15:0] CP_TIB_HI    = 16'h0FFF;
  localparam logic [15:0] CP_MARK1_LO  = 16'h0F71;
  localparam logic [15:0] CP_MARK1_HI  = 16'h0F84;
  localparam logic [15:0] CP_MARK2_LO  = 16'h0F90;
  localparam logic [15:0] CP_MARK2_HI  = 16'h0FBC;
  localparam logic [15:0] CP_TSHEG_LO  = 16'h0F0B;
  localparam logic [15:0] CP_TSHEG_HI  = 16'h0F0E;

  localparam logic [14:0] SUM_MAX = 15'h7FFF;

  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    if ((b & 8'hE0) == 8'hC0) begin
      n = LEAD_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = LEAD_THREE;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = LEAD_FOUR;
    end else begin
      n = LEAD_NONE;
    end
    return n;
  endfunction

  function automatic logic [4:0] single_w(input logic [7:0] b, input udw_cfg_t cfg);
    return (b == BYTE_NEWLINE) ? 5'd0 : cfg.narrow_width;
  endfunction

  function automatic logic [4:0] seq_w(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [1:0] need,
                                       input udw_cfg_t cfg);
    logic [15:0] cp;
    logic [4:0]  w;
    cp = {b0[3:0], b1[5:0], b2[5:0]};
    if (need != LEAD_THREE || cp < CP_TIB_LO || cp > CP_TIB_HI) begin
      w = cfg.wide_width;
    end else if ((cp >= CP_MARK1_LO && cp <= CP_MARK1_HI) ||
                 (cp >= CP_MARK2_LO && cp <= CP_MARK2_HI)) begin
      w = 5'd0;
    end else if (cp >= CP_TSHEG_LO && cp <= CP_TSHEG_HI) begin
      w = cfg.tsheg_width;
    end else begin
      w = cfg.narrow_width;
    end
    return w;
  endfunction

endpackage

/* rtl/udw_step.sv */
// ----------------------------------------------------------------------------
// udw_step
// Per-byte decode: sequence tracking, width of the byte, and flush of an
// open sequence on the final byte of a string.
// ----------------------------------------------------------------------------
module udw_step (
  input  udw_pkg::udw_in_t   word,
  input  udw_pkg::udw_hold_t hold,
  input  udw_pkg::udw_cfg_t  cfg,
  output udw_pkg::udw_step_t step
);

  udw_pkg::udw_hold_t hold_mid;
  logic [4:0]         add_byte;
  logic [6:0]         add_flush;
  logic [7:0]         t1;
  logic [7:0]         t2;
  logic [4:0]         w1;
  logic [4:0]         w2;
  logic               pair_12;

  always_comb begin
    hold_mid = hold;
    add_byte = 5'd0;
    if (hold.lead_class != udw_pkg::LEAD_NONE) begin
      if (hold.held_count >= hold.lead_class) begin
        add_byte = udw_pkg::seq_w(hold.held_bytes[7:0], hold.held_bytes[15:8],
                                  word.data_byte, hold.lead_class, cfg);
        hold_mid = '0;
      end else begin
        case (hold.held_count)
          2'd1:    hold_mid.held_bytes[15:8]  = word.data_byte;
          2'd2:    hold_mid.held_bytes[23:16] = word.data_byte;
          default: hold_mid.held_bytes[7:0]   = word.data_byte;
        endcase
        hold_mid.held_count = hold.held_count + 2'd1;
      end
    end else if (udw_pkg::lead_need(word.data_byte) == udw_pkg::LEAD_NONE) begin
      add_byte = udw_pkg::single_w(word.data_byte, cfg);
    end else begin
      hold_mid.held_bytes = {16'd0, word.data_byte};
      hold_mid.held_count = 2'd1;
      hold_mid.lead_class = udw_pkg::lead_need(word.data_byte);
    end
  end

  // Truncated tail: lead counts wide, held bytes reclassified
  always_comb begin
    t1      = hold_mid.held_bytes[15:8];
    t2      = hold_mid.held_bytes[23:16];
    pair_12 = (hold_mid.held_count == 2'd3) &&
              (udw_pkg::lead_need(t1) == udw_pkg::LEAD_TWO);
    w1      = 5'd0;
    w2      = 5'd0;
    if (hold_mid.held_count >= 2'd2) begin
      w1 = (udw_pkg::lead_need(t1) != udw_pkg::LEAD_NONE) ? cfg.wide_width
                                                           : udw_pkg::single_w(t1, cfg);
    end
    if (hold_mid.held_count == 2'd3 && !pair_12) begin
      w2 = (udw_pkg::lead_need(t2) != udw_pkg::LEAD_NONE) ? cfg.wide_width
                                                           : udw_pkg::single_w(t2, cfg);
    end
    add_flush = 7'({2'd0, cfg.wide_width}) + 7'({2'd0, w1}) + 7'({2'd0, w2});
  end

  always_comb begin
    step.hold = hold_mid;
    step.add  = {2'd0, add_byte};
    if (word.end_of_string) begin
      step.hold = '0;
      if (hold_mid.lead_class != udw_pkg::LEAD_NONE) begin
        step.add = add_flush;
      end
    end
  end

endmodule

/* rtl/utf8_display_width_top.sv */
// ----------------------------------------------------------------------------
// utf8_display_width_top
// Sums the pixel width of a UTF-8 string taken one byte per word.
// ----------------------------------------------------------------------------
// One byte is accepted every clock while in_ready is high. A string's width
// is registered when its final byte is accepted and held there until taken;
// in_ready drops only while that register is full and out_ready is low. Up
// to three bytes of a multibyte sequence are held; a string that ends inside
// a sequence is flushed in the same cycle as its final byte. The sum
// saturates at 32767 with saturated set. Width registers (narrow, wide,
// tsheg) are written through the cfg channel, which is always ready.
module utf8_display_width_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  udw_pkg::udw_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output udw_pkg::udw_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [udw_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [4:0]                cfg_data
);

  udw_pkg::udw_cfg_t  cfg;
  udw_pkg::udw_hold_t hold;
  udw_pkg::udw_step_t step;
  logic [14:0]        width_sum;
  logic               sum_clipped;
  logic [15:0]        sum_next;
  logic               over;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  udw_step u_step (
    .word (in_data),
    .hold (hold),
    .cfg  (cfg),
    .step (step)
  );

  assign sum_next = {1'b0, width_sum} + {9'd0, step.add};
  assign over     = sum_next[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.narrow_width <= 5'd8;
      cfg.wide_width   <= 5'd16;
      cfg.tsheg_width  <= 5'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        udw_pkg::REG_NARROW: cfg.narrow_width <= cfg_data;
        udw_pkg::REG_WIDE:   cfg.wide_width   <= cfg_data;
        udw_pkg::REG_TSHEG:  cfg.tsheg_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold        <= '0;
      width_sum   <= '0;
      sum_clipped <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire && in_data.end_of_string) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        hold <= step.hold;
        if (in_data.end_of_string) begin
          width_sum   <= '0;
          sum_clipped <= 1'b0;
        end else begin
          width_sum   <= over ? udw_pkg::SUM_MAX : sum_next[14:0];
          sum_clipped <= sum_clipped | over;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.end_of_string) begin
      out_data.text_width <= over ? udw_pkg::SUM_MAX : sum_next[14:0];
      out_data.saturated  <= sum_clipped | over;
    end
  end

endmodule

/* tb/tb_utf8_display_width_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_display_width_top
// Self-checking bench for the UTF-8 display width block. Byte words go in
// with random gaps while the result side stalls at random. A scoreboard
// predicts each string's width and clip flag and checks results in order.
// The run covers directed cases, random well-formed and broken text under
// several width settings, a long receiver hold-off and the saturation cap.
// ----------------------------------------------------------------------------
module tb_utf8_display_width_top;

  localparam int LIMIT_CYCLES = 800000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_BYTES  = 30;
  localparam int CAP_CHARS    = 1057;  // 1057 * 31 is exactly 32767

  localparam logic [4:0] SET_N [4] = '{5'd0, 5'd31, 5'd31, 5'd0};
  localparam logic [4:0] SET_W [4] = '{5'd0, 5'd31, 5'd0, 5'd31};
  localparam logic [4:0] SET_T [4] = '{5'd0, 5'd31, 5'd31, 5'd0};

  localparam logic [15:0] TIB_EDGES [14] = '{
    16'h0F00, 16'h0FFF, 16'h0F70, 16'h0F71, 16'h0F84, 16'h0F85, 16'h0F8F,
    16'h0F90, 16'h0FBC, 16'h0FBD, 16'h0F0A, 16'h0F0B, 16'h0F0E, 16'h0F0F
  };

  class width_scoreboard;
    udw_pkg::udw_out_t width_q[$];
    logic [4:0]  narrow_w = 5'd8;
    logic [4:0]  wide_w   = 5'd16;
    logic [4:0]  tsheg_w  = 5'd5;
    logic [23:0] held     = '0;
    logic [1:0]  held_cnt = '0;
    logic [1:0]  lead     = udw_pkg::LEAD_NONE;
    logic [14:0] run_sum  = '0;
    logic        clipped  = 1'b0;
    int          errors   = 0;
    int          words    = 0;
    int          strings  = 0;
    int          clips    = 0;

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void set_width(input logic [udw_pkg::CfgIdxW-1:0] idx, input logic [4:0] val);
      case (idx)
        udw_pkg::REG_NARROW: narrow_w = val;
        udw_pkg::REG_WIDE:   wide_w   = val;
        udw_pkg::REG_TSHEG:  tsheg_w  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return width_q.size();
    endfunction

    function logic [1:0] lead_kind(input logic [7:0] b);
      casez (b)
        8'b110?????: return udw_pkg::LEAD_TWO;
        8'b1110????: return udw_pkg::LEAD_THREE;
        8'b11110???: return udw_pkg::LEAD_FOUR;
        default:     return udw_pkg::LEAD_NONE;
      endcase
    endfunction

    function logic [4:0] byte_cost(input logic [7:0] b);
      return (b == udw_pkg::BYTE_NEWLINE) ? 5'd0 : narrow_w;
    endfunction

    function logic [4:0] char_cost(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [1:0] kind);
      logic [15:0] cp;
      cp = {b0[3:0], b1[5:0], b2[5:0]};
      if (kind != udw_pkg::LEAD_THREE || cp[15:8] != 8'h0F) return wide_w;
      if (cp >= udw_pkg::CP_MARK1_LO && cp <= udw_pkg::CP_MARK1_HI) return 5'd0;
      if (cp >= udw_pkg::CP_MARK2_LO && cp <= udw_pkg::CP_MARK2_HI) return 5'd0;
      if (cp >= udw_pkg::CP_TSHEG_LO && cp <= udw_pkg::CP_TSHEG_HI) return tsheg_w;
      return narrow_w;
    endfunction

    function void add_px(input logic [4:0] w);
      logic [15:0] s;
      s = {1'b0, run_sum} + 16'(w);
      if (s > {1'b0, udw_pkg::SUM_MAX}) begin
        run_sum = udw_pkg::SUM_MAX;
        clipped = 1'b1;
      end else begin
        run_sum = s[14:0];
      end
    endfunction

    // string ended inside a sequence: lead counts wide, rest re-parsed
    function void flush_hold();
      logic [7:0] hb [3];
      logic [1:0] k;
      int n;
      int i;
      hb[0] = held[7:0];
      hb[1] = held[15:8];
      hb[2] = held[23:16];
      n = held_cnt;
      i = 0;
      while (i < n) begin
        k = lead_kind(hb[i]);
        if (k == udw_pkg::LEAD_NONE) begin
          add_px(byte_cost(hb[i]));
          i++;
        end else if (i + int'(k) < n) begin
          add_px(char_cost(hb[i], hb[(i + 1) % 3], hb[(i + 2) % 3], k));
          i += int'(k) + 1;
        end else begin
          add_px(wide_w);
          i++;
        end
      end
      held = '0;
      held_cnt = '0;
      lead = udw_pkg::LEAD_NONE;
    endfunction

    function void note_word(input udw_pkg::udw_in_t w);
      udw_pkg::udw_out_t res;
      logic [1:0] k;
      words++;
      if (lead != udw_pkg::LEAD_NONE) begin
        if (held_cnt >= lead) begin
          add_px(char_cost(held[7:0], held[15:8], w.data_byte, lead));
          held = '0;
          held_cnt = '0;
          lead = udw_pkg::LEAD_NONE;
        end else begin
          held = held | (24'(w.data_byte) << (8 * int'(held_cnt)));
          held_cnt = held_cnt + 2'd1;
        end
      end else begin
        k = lead_kind(w.data_byte);
        if (k == udw_pkg::LEAD_NONE) begin
          add_px(byte_cost(w.data_byte));
        end else begin
          held = 24'(w.data_byte);
          held_cnt = 2'd1;
          lead = k;
        end
      end
      if (w.end_of_string) begin
        if (lead != udw_pkg::LEAD_NONE) flush_hold();
        res.text_width = run_sum;
        res.saturated = clipped;
        if (clipped) clips++;
        width_q.push_back(res);
        run_sum = '0;
        clipped = 1'b0;
      end
    endfunction

    task check_width(input udw_pkg::udw_out_t got);
      udw_pkg::udw_out_t want;
      if (width_q.size() == 0) begin
        report($sformatf("width %0d arrived with no string pending", got.text_width));
        return;
      end
      want = width_q.pop_front();
      strings++;
      if (got.text_width !== want.text_width)
        report($sformatf("string %0d: text_width %0d, predicted %0d",
                         strings, got.text_width, want.text_width));
      if (got.saturated !== want.saturated)
        report($sformatf("string %0d: saturated %0b, predicted %0b",
                         strings, got.saturated, want.saturated));
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  udw_pkg::udw_in_t             in_data;
  logic                         out_valid;
  logic                         out_ready;
  udw_pkg::udw_out_t            out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [udw_pkg::CfgIdxW-1:0]  cfg_index;
  logic [4:0]                   cfg_data;

  width_scoreboard sb;
  logic [7:0]      text_q[$];
  bit              tx_idle;
  bit              rx_idle;
  bit              hold_long;
  int              hold_cycles;
  int              bytes_sent;
  int              settings_run;
  int              cycles;

  utf8_display_width_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_width(out_data);
    end
  end

  function automatic int idle_len(input bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_cycles += LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        gap = idle_len(rx_idle);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] cont(input bit scramble);
    return {scramble ? 2'($urandom) : 2'b10, 6'($urandom)};
  endfunction

  function automatic void push3(input logic [15:0] cp, input bit scramble);
    text_q.push_back({4'hE, cp[15:12]});
    text_q.push_back({scramble ? 2'($urandom) : 2'b10, cp[11:6]});
    text_q.push_back({scramble ? 2'($urandom) : 2'b10, cp[5:0]});
  endfunction

  function automatic logic [15:0] tib_cp();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(udw_pkg::CP_MARK1_LO, udw_pkg::CP_MARK1_HI));
      1:       return 16'($urandom_range(udw_pkg::CP_MARK2_LO, udw_pkg::CP_MARK2_HI));
      2:       return 16'($urandom_range(udw_pkg::CP_TSHEG_LO, udw_pkg::CP_TSHEG_HI));
      3:       return {8'h0F, 8'($urandom)};
      default: return TIB_EDGES[$urandom_range(0, 13)];
    endcase
  endfunction

  function automatic logic [15:0] other_cp();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'h0EFF : 16'h1000;
    return 16'($urandom);
  endfunction

  // lead byte followed by too few continuation bytes
  function automatic void push_broken();
    int k;
    k = $urandom_range(1, 3);
    case (k)
      1:       text_q.push_back({3'b110, 5'($urandom)});
      2:       text_q.push_back({4'b1110, 4'($urandom)});
      default: text_q.push_back({5'b11110, 3'($urandom)});
    endcase
    repeat ($urandom_range(0, k - 1)) text_q.push_back(cont(1'b1));
  endfunction

  function automatic void add_char(input bit clean);
    int r;
    r = clean ? $urandom_range(0, 99) : $urandom_range(0, 139);
    if (r < 30) begin
      text_q.push_back(8'($urandom_range(1, 127)));
    end else if (r < 35) begin
      text_q.push_back(udw_pkg::BYTE_NEWLINE);
    end else if (r < 50) begin
      text_q.push_back({3'b110, 5'($urandom)});
      text_q.push_back(cont(!clean));
    end else if (r < 75) begin
      push3(tib_cp(), !clean);
    end else if (r < 85) begin
      push3(other_cp(), !clean);
    end else if (r < 100) begin
      text_q.push_back({5'b11110, 3'($urandom)});
      repeat (3) text_q.push_back(cont(!clean));
    end else if (r < 115) begin
      text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                            : 8'($urandom_range(8'hF8, 8'hFF)));
    end else if (r < 125) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      push_broken();
    end
  endfunction

  function automatic void build_text(input int max_chars);
    bit clean;
    clean = ($urandom_range(0, 99) < 80);
    text_q.delete();
    repeat ($urandom_range(1, max_chars)) add_char(clean);
    if (!clean && $urandom_range(0, 1) == 1) push_broken();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_len(tx_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.data_byte     <= b;
    in_data.end_of_string <= last;
    in_valid              <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic run_random(input int n_bytes, input int max_chars);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_text(($urandom_range(0, 9) == 0) ? 30 : max_chars);
      send_text();
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_widths(input logic [4:0] nw, input logic [4:0] ww,
                             input logic [4:0] tw);
    logic [udw_pkg::CfgIdxW-1:0] idx [3];
    logic [4:0]                  val [3];
    idx[0] = udw_pkg::REG_NARROW;
    idx[1] = udw_pkg::REG_WIDE;
    idx[2] = udw_pkg::REG_TSHEG;
    val[0] = nw;
    val[1] = ww;
    val[2] = tw;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_width(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = udw_pkg::REG_NARROW;
    cfg_data = '0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_long = 1'b0;
    hold_cycles = 0;
    bytes_sent = 0;
    settings_run = 1;
    cycles = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed, reset widths
    text_q = {8'h01, 8'h7F, 8'h0A, 8'h00, 8'hFF, 8'h80, 8'hC2, 8'hA9};
    send_text();
    text_q = {8'hE0, 8'hBD, 8'hB1, 8'hE0, 8'hBC, 8'h8B, 8'hE0, 8'hBC, 8'h80};
    send_text();
    text_q = {8'hE4, 8'hB8, 8'h80};
    send_text();
    text_q = {8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    text_q = {8'hF0, 8'hC2, 8'h41};
    send_text();
    text_q = {8'hE0, 8'hBD};
    send_text();

    for (int p = 0; p < 6; p++) begin
      settle();
      if (p < 4) load_widths(SET_N[p], SET_W[p], SET_T[p]);
      else load_widths(5'($urandom), 5'($urandom), 5'($urandom));
      for (int s = 0; s < 3; s++) begin
        tx_idle = (s != 1);
        rx_idle = (s != 1) && (p[0] || s == 0);
        run_random(PHASE_BYTES / 3, 6);
      end
    end

    // receiver holds off while short strings keep coming
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_long = 1'b1;
    run_random(60, 2);

    settle();
    load_widths(5'd31, 5'd31, 5'd31);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    text_q.delete();
    repeat (CAP_CHARS + 1) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    push3(udw_pkg::CP_MARK1_LO, 1'b0);
    push_broken();
    send_text();
    settle();

    $display("Run covered %0d bytes in %0d strings under %0d width settings.",
             sb.words, sb.strings, settings_run);
    $display("%0d sums clipped at the cap; receiver held off %0d cycles in one stretch.",
             sb.clips, hold_cycles);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/udw_pkg.sv
rtl/udw_step.sv
rtl/utf8_display_width_top.sv
tb/tb_utf8_display_width_top.sv
